// ===== sv/rtcse_pkg.sv =====
`default_nettype none

package rtcse_pkg;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] CFG_POLICY_ENABLE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_OFFSET    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_INTERVAL  = 2'd2;

  // time constants
  localparam int SecPerHour = 3600;
  localparam int SecPerDay  = 86400;
  localparam int MinIvW     = 20;

  // register reset values
  localparam logic        PolicyRst    = 1'b1;
  localparam logic [16:0] MinOffsetRst = 17'd2;
  localparam logic [MinIvW-1:0] MinIvRst = MinIvW'(24 * SecPerHour);

  // calendar limits: any date in a later year is past 2^32-1 seconds
  localparam logic [13:0] YearMin = 14'd2000;
  localparam logic [13:0] YearMax = 14'd2106;

  // seconds arithmetic width for the date conversion, wraps mod 2^36
  localparam int SecsW = 36;
  localparam logic [SecsW-1:0] SecPerYear = SecsW'(365 * SecPerDay);
  localparam logic [SecsW-1:0] SecPerDayW = SecsW'(SecPerDay);
  // era offset in seconds relative to the unix epoch, for era 4 and era 5
  localparam logic [SecsW-1:0] EraLoSecs =
    SecsW'((64'sd4 * 64'sd146097 - 64'sd719468) * 64'sd86400);
  localparam logic [SecsW-1:0] EraHiSecs =
    SecsW'((64'sd5 * 64'sd146097 - 64'sd719468) * 64'sd86400);

  typedef enum logic [2:0] {
    ST_SYNCED  = 3'd0,
    ST_INVALID = 3'd1,
    ST_NOCLOCK = 3'd2,
    ST_SMALL   = 3'd3,
    ST_RATE    = 3'd4
  } status_t;

  typedef struct packed {
    logic        action;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [31:0] forced_epoch;
    logic [31:0] clock_now;
    logic        clock_read_ok;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [31:0]        write_epoch;
    logic signed [31:0] clock_delta;
  } out_item_t;

  // converted request between the two logic stages
  typedef struct packed {
    logic        action;
    logic        date_ok;
    logic [31:0] target;
    logic [31:0] forced_epoch;
    logic [31:0] clock_now;
    logic        clock_read_ok;
  } conv_t;

  typedef struct packed {
    logic              policy_enable;
    logic [16:0]       min_delta;
    logic [MinIvW-1:0] min_iv_sec;
  } cfg_t;

  // day of the march-based year at which each month starts
  function automatic logic [8:0] month_doy(input logic [3:0] month);
    logic [8:0] doy;
    unique case (month)
      4'd3:    doy = 9'd0;
      4'd4:    doy = 9'd31;
      4'd5:    doy = 9'd61;
      4'd6:    doy = 9'd92;
      4'd7:    doy = 9'd122;
      4'd8:    doy = 9'd153;
      4'd9:    doy = 9'd184;
      4'd10:   doy = 9'd214;
      4'd11:   doy = 9'd245;
      4'd12:   doy = 9'd275;
      4'd1:    doy = 9'd306;
      4'd2:    doy = 9'd337;
      default: doy = 9'd0;
    endcase
    return doy;
  endfunction

endpackage

`default_nettype wire

// ===== sv/rtcse_civil.sv =====
`default_nettype none

module rtcse_civil (
  input  rtcse_pkg::in_item_t item,
  output rtcse_pkg::conv_t    conv
);

  logic        fields_ok;
  logic        m_low;
  logic [13:0] ya;
  logic [13:0] ya_off;
  logic        era_hi;
  logic [8:0]  yoe;
  logic [1:0]  c100;
  logic [9:0]  days_small;
  logic [16:0] hms;
  logic [rtcse_pkg::SecsW-1:0] yoe_secs;
  logic [rtcse_pkg::SecsW-1:0] days_secs;
  logic [rtcse_pkg::SecsW-1:0] era_secs;
  logic [rtcse_pkg::SecsW-1:0] secs;

  // field range check
  assign fields_ok = (item.year >= rtcse_pkg::YearMin) &&
                     (item.year <= rtcse_pkg::YearMax) &&
                     (item.month >= 7'd1) && (item.month <= 7'd12) &&
                     (item.day >= 7'd1) && (item.day <= 7'd31) &&
                     (item.hour <= 7'd23) && (item.minute <= 7'd59) &&
                     (item.second <= 7'd59);

  // march-based year; only eras 4 and 5 occur for accepted years
  assign m_low  = (item.month <= 7'd2);
  assign ya     = item.year - {13'd0, m_low};
  assign era_hi = (ya >= rtcse_pkg::YearMin);
  assign ya_off = ya - rtcse_pkg::YearMin;
  assign yoe    = era_hi ? ya_off[8:0] : 9'd399;

  // century count within the era
  always_comb begin
    if (yoe >= 9'd300) begin
      c100 = 2'd3;
    end else if (yoe >= 9'd200) begin
      c100 = 2'd2;
    end else if (yoe >= 9'd100) begin
      c100 = 2'd1;
    end else begin
      c100 = 2'd0;
    end
  end

  // leap days plus day of year
  assign days_small = {3'd0, yoe[8:2]} - {8'd0, c100}
                    + {1'b0, rtcse_pkg::month_doy(item.month[3:0])}
                    + {3'd0, item.day} - 10'd1;

  assign hms = 17'({10'd0, item.hour} * 17'(rtcse_pkg::SecPerHour))
             + 17'({10'd0, item.minute} * 17'd60)
             + {10'd0, item.second};

  // independent constant products summed once
  assign yoe_secs  = {27'd0, yoe} * rtcse_pkg::SecPerYear;
  assign days_secs = {26'd0, days_small} * rtcse_pkg::SecPerDayW;
  assign era_secs  = era_hi ? rtcse_pkg::EraHiSecs : rtcse_pkg::EraLoSecs;
  assign secs      = yoe_secs + days_secs + {19'd0, hms} + era_secs;

  always_comb begin
    conv.action        = item.action;
    conv.date_ok       = fields_ok && (secs[rtcse_pkg::SecsW-1:32] == '0);
    conv.target        = secs[31:0];
    conv.forced_epoch  = item.forced_epoch;
    conv.clock_now     = item.clock_now;
    conv.clock_read_ok = item.clock_read_ok;
  end

endmodule

`default_nettype wire

// ===== sv/rtcse_policy.sv =====
`default_nettype none

module rtcse_policy (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  rtcse_pkg::conv_t    conv,
  input  rtcse_pkg::cfg_t     cfg,
  output rtcse_pkg::out_item_t res
);

  logic [31:0] last_sync_r;
  logic [31:0] last_sync_nxt;
  logic [31:0] cur;
  logic [31:0] tgt;
  logic [31:0] offset;
  logic [31:0] mag;
  logic [31:0] ref_sec;
  logic [31:0] since;
  logic        small_off;
  logic        rate_hit;
  logic        sync;

  // target and current time, unreadable clock counts as zero
  assign cur    = conv.clock_read_ok ? conv.clock_now : 32'd0;
  assign tgt    = conv.action ? conv.forced_epoch : conv.target;
  assign offset = tgt - cur;
  assign mag    = offset[31] ? (32'd0 - offset) : offset;

  assign small_off = (mag <= {15'd0, cfg.min_delta});
  assign ref_sec   = (tgt > cur) ? tgt : cur;
  assign since     = ref_sec - last_sync_r;
  assign rate_hit  = (last_sync_r != 32'd0) &&
                     (since < {{(32-rtcse_pkg::MinIvW){1'b0}}, cfg.min_iv_sec});

  // decision in priority order
  always_comb begin
    sync            = 1'b0;
    res.status      = rtcse_pkg::ST_SYNCED;
    res.write_epoch = 32'd0;
    res.clock_delta = 32'sd0;
    priority if (conv.action) begin
      sync            = 1'b1;
      res.write_epoch = tgt;
      res.clock_delta = $signed(offset);
    end else if (!conv.date_ok) begin
      res.status = rtcse_pkg::ST_INVALID;
    end else if (!conv.clock_read_ok) begin
      res.status = rtcse_pkg::ST_NOCLOCK;
    end else if (cfg.policy_enable && small_off) begin
      res.status      = rtcse_pkg::ST_SMALL;
      res.clock_delta = $signed(offset);
    end else if (cfg.policy_enable && rate_hit) begin
      res.status      = rtcse_pkg::ST_RATE;
      res.clock_delta = $signed(offset);
    end else begin
      sync            = 1'b1;
      res.write_epoch = tgt;
      res.clock_delta = $signed(offset);
    end
  end

  // last sync epoch, zero means never synced
  assign last_sync_nxt = (fire && sync) ? tgt : last_sync_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sync_r <= 32'd0;
    end else begin
      last_sync_r <= last_sync_nxt;
    end
  end

  a_sync_updates_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (res.status == rtcse_pkg::ST_SYNCED) |=> last_sync_r == $past(res.write_epoch))
    else $error("last sync epoch not updated on synced beat");

  a_skip_keeps_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (res.status != rtcse_pkg::ST_SYNCED) |=> $stable(last_sync_r))
    else $error("last sync epoch changed on skipped beat");

  a_forced_syncs: assert property (@(posedge clk) disable iff (!rst_n)
    fire && conv.action |-> res.status == rtcse_pkg::ST_SYNCED)
    else $error("forced set not synced");

endmodule

`default_nettype wire

// ===== sv/rtc_sync_calendar_to_epoch_unit.sv =====
`default_nettype none

// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall   | rtcse_pkg::in_item_t
// out_    | output    | out_valid/out_stall | rtcse_pkg::out_item_t
// cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// one beat per cycle sustained while out_stall is low; a taken beat is registered
// after each step (input register, date conversion, policy and last-sync update)
// rst_n is synchronous: clears valid bits, config to defaults, last sync to 0
// out_stall holds the result register; bubbles ahead of it still fill, and
// in_stall rises only when every stage is full and the output is stalled
module rtc_sync_calendar_to_epoch_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rtcse_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rtcse_pkg::out_item_t                out_data,
  input  logic                                cfg_we,
  input  logic [rtcse_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [rtcse_pkg::CfgDataW-1:0]      cfg_wdata
);

  logic                 v0_r, v0_nxt;
  logic                 v1_r, v1_nxt;
  logic                 v2_r, v2_nxt;
  rtcse_pkg::in_item_t  s0_r;
  rtcse_pkg::conv_t     s1_r;
  rtcse_pkg::out_item_t s2_r;
  rtcse_pkg::conv_t     conv;
  rtcse_pkg::out_item_t res;
  rtcse_pkg::cfg_t      cfg_r, cfg_nxt;
  logic                 adv0, adv1, adv2;
  logic                 fire;

  // stage advance, each stage moves when empty or when the next one moves
  assign adv2 = !v2_r || !out_stall;
  assign adv1 = !v1_r || adv2;
  assign adv0 = !v0_r || adv1;
  assign fire = adv2 && v1_r;

  assign in_stall  = !adv0;
  assign out_valid = v2_r;
  assign out_data  = s2_r;

  assign v0_nxt = adv0 ? in_valid : v0_r;
  assign v1_nxt = adv1 ? v0_r : v1_r;
  assign v2_nxt = adv2 ? v1_r : v2_r;

  // configuration writes, interval kept in seconds
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rtcse_pkg::CFG_POLICY_ENABLE: cfg_nxt.policy_enable = cfg_wdata[0];
        rtcse_pkg::CFG_MIN_OFFSET:    cfg_nxt.min_delta = cfg_wdata;
        rtcse_pkg::CFG_MIN_INTERVAL:  cfg_nxt.min_iv_sec =
          rtcse_pkg::MinIvW'({{(rtcse_pkg::MinIvW-8){1'b0}}, cfg_wdata[7:0]}
                             * rtcse_pkg::MinIvW'(rtcse_pkg::SecPerHour));
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  rtcse_civil u_civil (
    .item (s0_r),
    .conv (conv)
  );

  rtcse_policy u_policy (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .conv  (s1_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r                 <= 1'b0;
      v1_r                 <= 1'b0;
      v2_r                 <= 1'b0;
      cfg_r.policy_enable  <= rtcse_pkg::PolicyRst;
      cfg_r.min_delta      <= rtcse_pkg::MinOffsetRst;
      cfg_r.min_iv_sec     <= rtcse_pkg::MinIvRst;
    end else begin
      v0_r  <= v0_nxt;
      v1_r  <= v1_nxt;
      v2_r  <= v2_nxt;
      cfg_r <= cfg_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && adv0) begin
      s0_r <= in_data;
    end
    if (v0_r && adv1) begin
      s1_r <= conv;
    end
    if (fire) begin
      s2_r <= res;
    end
  end

  a_skip_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && (s2_r.status != rtcse_pkg::ST_SYNCED) |-> s2_r.write_epoch == 32'd0)
    else $error("write epoch set on a skipped result");

  a_reject_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && (s2_r.status == rtcse_pkg::ST_INVALID || s2_r.status == rtcse_pkg::ST_NOCLOCK)
    |-> s2_r.clock_delta == 32'sd0)
    else $error("offset set on a rejected request");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v0_r && v1_r && v2_r && out_stall)
    else $error("input stalled with a free stage");

  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v2_r) |-> $past(v1_r))
    else $error("result appeared without a converted request");

endmodule

`default_nettype wire
